FILE: sv/two_button_menu_fsm_defines.svh
// Assertion macros used by the menu controller core module.
`ifndef TWO_BUTTON_MENU_FSM_DEFINES_SVH
`define TWO_BUTTON_MENU_FSM_DEFINES_SVH

// Check a property at every rising clk edge outside reset.
`define TBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clk edge, reset included.
`define TBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tbm_pkg.sv
`timescale 1ns / 1ps

package tbm_pkg;

  localparam int unsigned STEP_BITS_DEF  = 4;
  localparam int unsigned TIMER_BITS_DEF = 32;

  localparam int unsigned FIELD_W  = 4;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] NUM_STEPS_RST        = 4'd4;
  localparam logic [CFG_W-1:0]   OPEN_TIMEOUT_RST     = 32'd10000;
  localparam logic [CFG_W-1:0]   SELECTED_TIMEOUT_RST = 32'd5000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_STEPS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OPEN_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SELECTED_TIMEOUT = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_NEXT     = 3'd0,
    REQ_ACCEPT   = 3'd1,
    REQ_LEAVE    = 3'd2,
    REQ_EXIT     = 3'd3,
    REQ_TICK     = 3'd4,
    REQ_LOAD_BRT = 3'd5,
    REQ_LOAD_INT = 3'd6
  } req_t;

  typedef enum logic [FIELD_W-1:0] {
    EV_NONE          = 4'd0,
    EV_STEP          = 4'd1,
    EV_FIRST_CHANGE  = 4'd2,
    EV_SECOND_CHANGE = 4'd3,
    EV_SELECT        = 4'd4,
    EV_APPLY         = 4'd5,
    EV_FIRST_ENTER   = 4'd6,
    EV_SECOND_ENTER  = 4'd7,
    EV_EXIT          = 4'd8
  } evt_t;

  typedef struct packed {
    logic [FIELD_W-1:0] num_steps;
    logic [CFG_W-1:0]   open_timeout;
    logic [CFG_W-1:0]   selected_timeout;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] returned_value;
    logic [FIELD_W-1:0] current_step;
    logic [FIELD_W-1:0] selected_step;
    logic [FIELD_W-1:0] brightness_value;
    logic [FIELD_W-1:0] interval_value;
    logic               menu_open;
    evt_t               event_code;
  } res_t;

  // value + 1, back to 1 once it passes num_steps - 1
  function automatic logic [FIELD_W-1:0] wrap_setting(input logic [FIELD_W-1:0] v,
                                                      input logic [FIELD_W-1:0] num);
    logic [FIELD_W+1:0] n;
    n = {2'b00, v} + 6'd1;
    if ((n + 6'd1) > {2'b00, num}) begin
      n = 6'd1;
    end
    return n[FIELD_W-1:0];
  endfunction

endpackage

FILE: sv/two_button_menu_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// in_      in   tuser: req_type[2:0]; tdata: load_value[3:0], zero pad to 8 bits
// out_     out  tdata: returned, current, selected, brightness, interval, open, event
// cfg_     in   write enable, register index, 32-bit write data, no read-back
//
// One event a cycle sustained while out_tready stays high.
// Input register, then the next-state logic, then the output register.
// Synchronous active-low reset clears the menu state and loads register defaults.
// An output stall holds the output register and the input register behind it.
module two_button_menu_fsm #(
  parameter int unsigned STEP_BITS  = tbm_pkg::STEP_BITS_DEF,
  parameter int unsigned TIMER_BITS = tbm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output wire logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // load_value[3:0]
  input  wire logic [tbm_pkg::REQ_W-1:0]      in_tuser,   // req_type[2:0]
  output wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // returned_value[3:0], current_step[7:4], selected_step[11:8],
  // brightness_value[15:12], interval_value[19:16], menu_open[20], event_code[24:21]
  output wire logic [31:0]                    out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [tbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbm_pkg::CFG_W-1:0]      cfg_wdata
);

  tbm_pkg::cfg_t                 cfg;
  tbm_pkg::res_t                 res;
  tbm_pkg::res_t                 out_r;
  logic                          out_valid_r;
  logic                          in_valid_r;
  logic [tbm_pkg::REQ_W-1:0]     req_r;
  logic [tbm_pkg::FIELD_W-1:0]   load_r;
  logic                          advance;
  logic                          fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  tbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tbm_core #(
    .STEP_BITS  (STEP_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .req   (req_r),
    .load  (load_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r  <= in_tuser;
      load_r <= in_tdata[tbm_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.event_code, out_r.menu_open, out_r.interval_value,
                       out_r.brightness_value, out_r.selected_step, out_r.current_step,
                       out_r.returned_value};

endmodule

`default_nettype wire

FILE: sv/tbm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module tbm_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbm_pkg::CFG_W-1:0]      cfg_wdata,
  output tbm_pkg::cfg_t                       cfg
);

  tbm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_steps        <= tbm_pkg::NUM_STEPS_RST;
      cfg_r.open_timeout     <= tbm_pkg::OPEN_TIMEOUT_RST;
      cfg_r.selected_timeout <= tbm_pkg::SELECTED_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tbm_pkg::CFG_IDX_NUM_STEPS: begin
          cfg_r.num_steps <= cfg_wdata[tbm_pkg::FIELD_W-1:0];
        end
        tbm_pkg::CFG_IDX_OPEN_TIMEOUT: begin
          cfg_r.open_timeout <= cfg_wdata;
        end
        tbm_pkg::CFG_IDX_SELECTED_TIMEOUT: begin
          cfg_r.selected_timeout <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/tbm_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "two_button_menu_fsm_defines.svh"

module tbm_core #(
  parameter int unsigned STEP_BITS  = tbm_pkg::STEP_BITS_DEF,
  parameter int unsigned TIMER_BITS = tbm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tbm_pkg::cfg_t                 cfg,
  input  wire logic                          fire,
  input  wire logic [tbm_pkg::REQ_W-1:0]     req,
  input  wire logic [tbm_pkg::FIELD_W-1:0]   load,
  output tbm_pkg::res_t                      res
);

  localparam int unsigned CW = (STEP_BITS + 1 > tbm_pkg::FIELD_W + 1) ?
                               STEP_BITS + 1 : tbm_pkg::FIELD_W + 1;
  localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1);
  localparam logic [STEP_BITS-1:0] STEP_TWO = STEP_BITS'(2);

  logic                          open_r, open_nxt;
  logic [STEP_BITS-1:0]          step_r, step_nxt;
  logic [STEP_BITS-1:0]          sel_r, sel_nxt;
  logic [tbm_pkg::FIELD_W-1:0]   brt_r, brt_nxt;
  logic [tbm_pkg::FIELD_W-1:0]   int_r, int_nxt;
  logic [TIMER_BITS-1:0]         idle_r, idle_nxt;
  logic [tbm_pkg::FIELD_W-1:0]   ret;
  logic                          have_ret;
  tbm_pkg::evt_t                 ev;

  always_comb begin
    logic [CW-1:0]           s;
    logic [tbm_pkg::CFG_W-1:0] wait_ticks;
    logic                    do_next;

    open_nxt = open_r;
    step_nxt = step_r;
    sel_nxt  = sel_r;
    brt_nxt  = brt_r;
    int_nxt  = int_r;
    idle_nxt = idle_r;
    ev       = tbm_pkg::EV_NONE;
    ret      = '0;
    have_ret = 1'b0;
    do_next  = 1'b0;
    s        = CW'(step_r) + CW'(1);
    wait_ticks = (sel_r == '0) ? cfg.open_timeout : cfg.selected_timeout;

    case (tbm_pkg::req_t'(req))
      tbm_pkg::REQ_NEXT: begin
        do_next = open_r;
      end
      tbm_pkg::REQ_ACCEPT: begin
        if (!open_r) begin
          open_nxt = 1'b1;
          do_next  = 1'b1;
        end else begin
          idle_nxt = '0;
          if (step_r != STEP_ONE && step_r != STEP_TWO && sel_r != '0) begin
            sel_nxt = '0;
            ev      = tbm_pkg::EV_APPLY;
          end else if (step_r == STEP_ONE && sel_r != STEP_ONE) begin
            sel_nxt = STEP_ONE;
            ev      = tbm_pkg::EV_FIRST_ENTER;
          end else if (step_r == STEP_TWO && sel_r != STEP_TWO) begin
            sel_nxt = STEP_TWO;
            ev      = tbm_pkg::EV_SECOND_ENTER;
          end else begin
            sel_nxt = step_r;
            ev      = tbm_pkg::EV_SELECT;
          end
        end
      end
      tbm_pkg::REQ_LEAVE: begin
        idle_nxt = '0;
        sel_nxt  = '0;
      end
      tbm_pkg::REQ_EXIT: begin
        open_nxt = 1'b0;
        step_nxt = '0;
        sel_nxt  = '0;
        idle_nxt = '0;
        ev       = tbm_pkg::EV_EXIT;
      end
      tbm_pkg::REQ_TICK: begin
        if (open_r) begin
          if (idle_r != '1) begin
            idle_nxt = idle_r + TIMER_BITS'(1);
          end
          if (tbm_pkg::CFG_W'(idle_nxt) >= wait_ticks) begin
            idle_nxt = '0;
            sel_nxt  = '0;
            if (sel_r == '0) begin
              open_nxt = 1'b0;
              step_nxt = '0;
              ev       = tbm_pkg::EV_EXIT;
            end
          end
        end
      end
      tbm_pkg::REQ_LOAD_BRT: begin
        brt_nxt = load;
      end
      tbm_pkg::REQ_LOAD_INT: begin
        int_nxt = load;
      end
      default: begin
      end
    endcase

    if (do_next) begin
      idle_nxt = '0;
      have_ret = 1'b1;
      if (sel_r == STEP_ONE) begin
        brt_nxt = tbm_pkg::wrap_setting(brt_r, cfg.num_steps);
        ev      = tbm_pkg::EV_FIRST_CHANGE;
        ret     = brt_nxt;
      end else if (sel_r == STEP_TWO) begin
        int_nxt = tbm_pkg::wrap_setting(int_r, cfg.num_steps);
        ev      = tbm_pkg::EV_SECOND_CHANGE;
        ret     = int_nxt;
      end else begin
        if (step_r != '0 && sel_r == step_r) begin
          sel_nxt = '0;
        end else begin
          if (s > CW'(cfg.num_steps)) begin
            s = CW'(1);
          end
          step_nxt = STEP_BITS'(s);
        end
        ev  = tbm_pkg::EV_STEP;
        ret = tbm_pkg::FIELD_W'(CW'(step_nxt));
      end
    end

    if (!have_ret) begin
      ret = tbm_pkg::FIELD_W'(CW'(step_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      step_r <= '0;
      sel_r  <= '0;
      brt_r  <= '0;
      int_r  <= '0;
      idle_r <= '0;
    end else if (fire) begin
      open_r <= open_nxt;
      step_r <= step_nxt;
      sel_r  <= sel_nxt;
      brt_r  <= brt_nxt;
      int_r  <= int_nxt;
      idle_r <= idle_nxt;
    end
  end

  assign res.returned_value   = ret;
  assign res.current_step     = tbm_pkg::FIELD_W'(CW'(step_nxt));
  assign res.selected_step    = tbm_pkg::FIELD_W'(CW'(sel_nxt));
  assign res.brightness_value = brt_nxt;
  assign res.interval_value   = int_nxt;
  assign res.menu_open        = open_nxt;
  assign res.event_code       = ev;

  `TBM_ASSERT(a_closed_clear, !open_r |-> (step_r == '0 && sel_r == '0), "closed menu holds a step")
  `TBM_ASSERT(a_sel_is_step, (sel_r == '0 || sel_r == step_r), "selection differs from step")
  `TBM_ASSERT(a_exit_clears, (fire && req == tbm_pkg::REQ_EXIT) |=> (!open_r && idle_r == '0), "exit left state")
  `TBM_ASSERT(a_open_by_accept, $rose(open_r) |-> $past(fire && req == tbm_pkg::REQ_ACCEPT), "menu opened without accept")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 215;

  // laid out as on out_tdata, event code in the top bits
  typedef struct packed {
    logic [3:0] evt;
    logic       open;
    logic [3:0] intv;
    logic [3:0] brt;
    logic [3:0] sel;
    logic [3:0] step;
    logic [3:0] ret;
  } menu_res_t;

  typedef struct packed {
    tbm_pkg::req_t req;
    logic [3:0]    load;
    logic          typed;
    menu_res_t     fixed;
  } dir_row_t;

  localparam menu_res_t NO_FIXED   = '0;
  localparam menu_res_t ALL_CLOSED = '{tbm_pkg::EV_NONE, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
  localparam menu_res_t CLOSED_EXIT = '{tbm_pkg::EV_EXIT, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
  localparam int DIR_N = 29;

  // run with num_steps 4, open timeout 3, selected timeout 2
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b1, ALL_CLOSED},
    '{tbm_pkg::REQ_TICK,     4'd0,  1'b1, ALL_CLOSED},
    '{tbm_pkg::REQ_LEAVE,    4'd0,  1'b1, ALL_CLOSED},
    '{tbm_pkg::REQ_EXIT,     4'd0,  1'b1, CLOSED_EXIT},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_LOAD_BRT, 4'd15, 1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_LEAVE,    4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_LOAD_INT, 4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_TICK,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_TICK,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_NEXT,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_TICK,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_TICK,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_TICK,     4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_ACCEPT,   4'd0,  1'b0, NO_FIXED},
    '{tbm_pkg::REQ_EXIT,     4'd10, 1'b0, NO_FIXED}
  };

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;
  logic [tbm_pkg::REQ_W-1:0]     in_tuser   = tbm_pkg::REQ_NEXT;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [31:0]                   out_tdata;
  logic                          cfg_we     = 1'b0;
  logic [tbm_pkg::CFG_IDX_W-1:0] cfg_index  = tbm_pkg::CFG_IDX_NUM_STEPS;
  logic [tbm_pkg::CFG_W-1:0]     cfg_wdata  = '0;

  // predicted menu state and register copies
  logic        m_open;
  logic [3:0]  m_step, m_sel, m_brt, m_intv;
  logic [31:0] m_idle;
  logic [3:0]  cfg_steps;
  logic [31:0] cfg_open_to, cfg_sel_to;

  menu_res_t   expected_beats[$];
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;

  two_button_menu_fsm i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [3:0] wrap_value(logic [3:0] v);
    int unsigned n;
    n = v + 1;
    if (n + 1 > cfg_steps) begin
      n = 1;
    end
    return 4'(n);
  endfunction

  function automatic void close_menu();
    m_step = '0;
    m_sel  = '0;
    m_open = 1'b0;
    m_idle = '0;
  endfunction

  function automatic logic [3:0] advance_menu(output logic [3:0] ev);
    int unsigned s;
    m_idle = '0;
    if (m_sel == 4'd1) begin
      m_brt = wrap_value(m_brt);
      ev = tbm_pkg::EV_FIRST_CHANGE;
      return m_brt;
    end
    if (m_sel == 4'd2) begin
      m_intv = wrap_value(m_intv);
      ev = tbm_pkg::EV_SECOND_CHANGE;
      return m_intv;
    end
    if (m_step != 0 && m_sel == m_step) begin
      m_sel = '0;
    end else begin
      s = m_step + 1;
      if (s > cfg_steps) begin
        s = 1;
      end
      m_step = 4'(s);
    end
    ev = tbm_pkg::EV_STEP;
    return m_step;
  endfunction

  function automatic menu_res_t menu_predict(tbm_pkg::req_t req, logic [3:0] load);
    menu_res_t   r;
    logic [3:0]  ev;
    logic [3:0]  ret;
    logic        has_ret;
    logic [31:0] limit;
    ev      = tbm_pkg::EV_NONE;
    ret     = '0;
    has_ret = 1'b0;
    case (req)
      tbm_pkg::REQ_NEXT: begin
        if (m_open) begin
          ret = advance_menu(ev);
          has_ret = 1'b1;
        end
      end
      tbm_pkg::REQ_ACCEPT: begin
        if (!m_open) begin
          m_open = 1'b1;
          ret = advance_menu(ev);
          has_ret = 1'b1;
        end else begin
          m_idle = '0;
          if (m_step != 4'd1 && m_step != 4'd2 && m_sel != 0) begin
            m_sel = '0;
            ev = tbm_pkg::EV_APPLY;
          end else if (m_step == 4'd1 && m_sel != 4'd1) begin
            m_sel = 4'd1;
            ev = tbm_pkg::EV_FIRST_ENTER;
          end else if (m_step == 4'd2 && m_sel != 4'd2) begin
            m_sel = 4'd2;
            ev = tbm_pkg::EV_SECOND_ENTER;
          end else begin
            m_sel = m_step;
            ev = tbm_pkg::EV_SELECT;
          end
        end
      end
      tbm_pkg::REQ_LEAVE: begin
        m_idle = '0;
        m_sel  = '0;
      end
      tbm_pkg::REQ_EXIT: begin
        close_menu();
        ev = tbm_pkg::EV_EXIT;
      end
      tbm_pkg::REQ_TICK: begin
        if (m_open) begin
          limit = (m_sel == 0) ? cfg_open_to : cfg_sel_to;
          if (m_idle != 32'hFFFF_FFFF) begin
            m_idle = m_idle + 1;
          end
          if (m_idle >= limit) begin
            if (m_sel == 0) begin
              close_menu();
              ev = tbm_pkg::EV_EXIT;
            end else begin
              m_idle = '0;
              m_sel  = '0;
            end
          end
        end
      end
      tbm_pkg::REQ_LOAD_BRT: m_brt = load;
      tbm_pkg::REQ_LOAD_INT: m_intv = load;
      default: ;
    endcase
    if (!has_ret) begin
      ret = m_step;
    end
    r.ret  = ret;
    r.step = m_step;
    r.sel  = m_sel;
    r.brt  = m_brt;
    r.intv = m_intv;
    r.open = m_open;
    r.evt  = ev;
    return r;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic send_beat(tbm_pkg::req_t req, logic [3:0] load, logic typed,
                           menu_res_t fixed);
    menu_res_t pred;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0000, load};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    pred = menu_predict(req, load);
    expected_beats.push_back(typed ? fixed : pred);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic drain_beats();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [tbm_pkg::CFG_IDX_W-1:0] idx, logic [tbm_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      tbm_pkg::CFG_IDX_NUM_STEPS:    cfg_steps   = data[3:0];
      tbm_pkg::CFG_IDX_OPEN_TIMEOUT: cfg_open_to = data;
      default:                       cfg_sel_to  = data;
    endcase
  endtask

  task automatic set_config(logic [3:0] num, logic [31:0] open_to, logic [31:0] sel_to);
    drain_beats();
    cfg_write(tbm_pkg::CFG_IDX_NUM_STEPS, {28'd0, num});
    cfg_write(tbm_pkg::CFG_IDX_OPEN_TIMEOUT, open_to);
    cfg_write(tbm_pkg::CFG_IDX_SELECTED_TIMEOUT, sel_to);
  endtask

  task automatic random_phase(int unsigned phase);
    int unsigned   done_items;
    int unsigned   run;
    int unsigned   pick;
    tbm_pkg::req_t req;
    done_items = 0;
    while (done_items < PHASE_ITEMS) begin
      if (phase == 3 && done_items >= 100 && done_items < 105) begin
        drain_beats();
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 45) : 1;
      repeat (run) begin
        pick = $urandom_range(0, 99);
        if (run > 1)         req = tbm_pkg::REQ_TICK;
        else if (pick < 28)  req = tbm_pkg::REQ_NEXT;
        else if (pick < 55)  req = tbm_pkg::REQ_ACCEPT;
        else if (pick < 75)  req = tbm_pkg::REQ_TICK;
        else if (pick < 81)  req = tbm_pkg::REQ_LEAVE;
        else if (pick < 84)  req = tbm_pkg::REQ_EXIT;
        else if (pick < 92)  req = tbm_pkg::REQ_LOAD_BRT;
        else                 req = tbm_pkg::REQ_LOAD_INT;
        done_items++;
        send_beat(req, 4'($urandom_range(0, 15)), 1'b0, NO_FIXED);
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (stall_tick % 4) != 0;
    endcase
  end

  always @(posedge clk) begin
    menu_res_t got;
    menu_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = menu_res_t'(out_tdata[24:0]);
      if (expected_beats.size() == 0) begin
        $error("output beat with nothing pending: %h", out_tdata);
        err_cnt++;
      end else begin
        want = expected_beats.pop_front();
        check_field("returned_value", want.ret, got.ret);
        check_field("current_step", want.step, got.step);
        check_field("selected_step", want.sel, got.sel);
        check_field("brightness_value", want.brt, got.brt);
        check_field("interval_value", want.intv, got.intv);
        check_field("menu_open", {3'b000, want.open}, {3'b000, got.open});
        check_field("event_code", want.evt, got.evt);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    m_open      = 1'b0;
    m_step      = '0;
    m_sel       = '0;
    m_brt       = '0;
    m_intv      = '0;
    m_idle      = '0;
    cfg_steps   = tbm_pkg::NUM_STEPS_RST;
    cfg_open_to = tbm_pkg::OPEN_TIMEOUT_RST;
    cfg_sel_to  = tbm_pkg::SELECTED_TIMEOUT_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    set_config(4'd4, 32'd3, 32'd2);
    for (int i = 0; i < DIR_N; i++) begin
      send_beat(DIR_ROWS[i].req, DIR_ROWS[i].load, DIR_ROWS[i].typed, DIR_ROWS[i].fixed);
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        set_config(4'd2, 32'd1, 32'd1);
      end else if (p == 1) begin
        set_config(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end else if (p == 2) begin
        set_config(4'd15, 32'd1, 32'hFFFF_FFFF);
      end else begin
        set_config(4'($urandom_range(2, 15)), $urandom_range(1, 40), $urandom_range(1, 40));
      end
      random_phase(p);
    end

    drain_beats();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && expected_beats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
